// ===== hdl/adaptive_mean_threshold_defines.svh =====
// Assertion macros for the adaptive mean threshold block
`ifndef ADAPTIVE_MEAN_THRESHOLD_DEFINES_SVH
`define ADAPTIVE_MEAN_THRESHOLD_DEFINES_SVH
`ifndef ASSERT_OFF
`define AMT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define AMT_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> cons) \
        else $error(msg);
`else
`define AMT_ASSERT(lbl, prop, msg)
`define AMT_ASSERT_IMPL(lbl, ante, cons, msg)
`endif
`endif

// ===== hdl/amt_pkg.sv =====
// Shared widths, register codes and constants of the adaptive mean threshold block
package amt_pkg;
    localparam int PIX_W      = 8;
    localparam int PIX_MAX    = 255;
    localparam int THR_W      = 8;
    localparam int FW_W       = 11;
    localparam int FH_W       = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd2;

    localparam logic [THR_W-1:0] THR_RST = 8'd5;
    localparam logic [FW_W-1:0]  FW_RST  = 11'd640;
    localparam logic [FH_W-1:0]  FH_RST  = 12'd480;

    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = 3;
    localparam int FIFO_CW    = 4;

    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic             last;
    } t_res;
endpackage

// ===== hdl/amt_in_if.sv =====
// Input pixel channel of the adaptive mean threshold block
interface amt_in_if import amt_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             mode;
    logic [PIX_W-1:0] pixel;

    modport source (output valid, output mode, output pixel, input ready);
    modport sink (input valid, input mode, input pixel, output ready);
endinterface

// ===== hdl/amt_out_if.sv =====
// Result channel of the adaptive mean threshold block
interface amt_out_if import amt_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] out_pixel;
    logic             out_last;

    modport source (output valid, output out_pixel, output out_last, input ready);
    modport sink (input valid, input out_pixel, input out_last, output ready);
endinterface

// ===== hdl/adaptive_mean_threshold.sv =====
// Adaptive mean threshold over a square window on a raster stream of gray pixels.
// Takes one word per cycle, pixel or drain, while input ready is high: the pixel is
// written into a ring line store while two copies of that store serve the center
// pixel and the pixel BLOCK_SIZE rows up, and a column-sum memory is read, updated
// and written back with forwarding, so nothing interlocks. A pixel's result is
// caused by the word HALF rows plus HALF pixels later (HALF = BLOCK_SIZE/2); drain
// words flush the pending tail of a frame. An eight-entry result queue, reserved at
// accept time, sets how far the output side may stall before input ready drops. No
// clearing pass is needed after reset.
`include "adaptive_mean_threshold_defines.svh"
module adaptive_mean_threshold import amt_pkg::*; #(
    parameter int BLOCK_SIZE = 15,
    parameter int MAX_WIDTH  = 1024
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    amt_in_if.sink                i_pix,
    amt_out_if.source             o_res
);
    localparam int HALF    = BLOCK_SIZE / 2;
    localparam int RING    = (BLOCK_SIZE + 2) * MAX_WIDTH;
    localparam int RING_AW = $clog2(RING);
    localparam int COL_AW  = $clog2(MAX_WIDTH);
    localparam int W_W     = $clog2(MAX_WIDTH + 1);
    localparam int EW      = (W_W > FW_W) ? W_W : FW_W;
    localparam int LAG_MAX = HALF * MAX_WIDTH + HALF;
    localparam int PEND_W  = $clog2(LAG_MAX + 1);
    localparam int COL_W   = $clog2(BLOCK_SIZE * PIX_MAX + 1);
    localparam int DIV     = BLOCK_SIZE * BLOCK_SIZE;
    localparam int WS_W    = $clog2(DIV * PIX_MAX + 1);
    localparam int SHIFT   = WS_W + $clog2(DIV);
    localparam int RECIP   = ((1 << SHIFT) + DIV - 1) / DIV;
    localparam int RCP_W   = $clog2(RECIP + 1);
    localparam int PROD_W  = WS_W + RCP_W;

    logic [THR_W-1:0]   r_thr;
    logic [FW_W-1:0]    r_fw;
    logic [FH_W-1:0]    r_fh;
    logic [RING_AW-1:0] r_wr;
    logic [PEND_W-1:0]  r_pend;
    logic [COL_AW-1:0]  r_in_col;
    logic [FH_W-1:0]    r_in_row;
    logic [COL_AW-1:0]  r_out_col;
    logic [FH_W-1:0]    r_out_row;
    logic               r_v1, r_v2, r_v3, r_v4;
    logic [FIFO_CW-1:0] r_cred;
    logic [FIFO_CW-1:0] r_fifo_cnt;
    logic [FIFO_AW-1:0] r_fifo_wp;
    logic [FIFO_AW-1:0] r_fifo_rp;
    t_res               r_fifo [FIFO_DEPTH];
    logic               r_fwd_vld;
    logic [COL_AW-1:0]  r_fwd_col;
    logic [COL_W-1:0]   r_fwd_val;

    logic               r_em1, r_pi1, r_row0_1, r_sub1, r_c0_1, r_cge1, r_int1, r_last1;
    logic [PIX_W-1:0]   r_px1;
    logic [COL_AW-1:0]  r_col1;
    logic               r_em2, r_pi2, r_c0_2, r_cge2, r_int2, r_last2;
    logic [COL_W-1:0]   r_colnew2;
    logic [PIX_W-1:0]   r_cpix2;
    logic               r_em3, r_int3, r_last3;
    logic [WS_W-1:0]    r_ws3;
    logic [PIX_W-1:0]   r_cpix3;
    logic               r_em4, r_int4, r_last4;
    logic [PROD_W-1:0]  r_prod4;
    logic [PIX_W-1:0]   r_cpix4;
    logic [WS_W-1:0]    r_ws;
    logic [COL_W-1:0]   r_shift [BLOCK_SIZE];

    logic [EW-1:0]      w_fw_ext, w_w_clamp;
    logic [W_W-1:0]     w_w;
    logic [FH_W-1:0]    w_h;
    logic [PEND_W-1:0]  w_lag;
    logic [RING_AW-1:0] w_bsw;
    logic [RING_AW:0]   w_pos_d, w_up_d;
    logic [RING_AW-1:0] w_pos, w_up;
    logic               w_acc, w_pix, w_drn, w_emit, w_pop, w_push;
    logic               w_out_int, w_out_last, w_in_col_end, w_in_row_end;
    logic [PIX_W-1:0]   w_ctr_rdata, w_up_rdata;
    logic [COL_W-1:0]   w_col_rdata, w_col_old, w_colnew;
    logic [WS_W-1:0]    w_ws_n;
    logic [PROD_W-1:0]  w_mean, w_lhs;
    logic [PIX_W-1:0]   w_res_pix;

    assign w_fw_ext  = EW'(r_fw);
    assign w_w_clamp = (w_fw_ext > EW'(MAX_WIDTH)) ? EW'(MAX_WIDTH) : w_fw_ext;
    assign w_w       = (w_w_clamp == '0) ? W_W'(1) : W_W'(w_w_clamp);
    assign w_h       = (r_fh == '0) ? FH_W'(1) : r_fh;
    assign w_lag     = PEND_W'(HALF * w_w + HALF);
    assign w_bsw     = RING_AW'(BLOCK_SIZE * w_w);

    assign w_pos_d = {1'b0, r_wr} - (RING_AW+1)'(r_pend);
    assign w_pos   = w_pos_d[RING_AW] ? RING_AW'(w_pos_d + (RING_AW+1)'(RING))
                                      : w_pos_d[RING_AW-1:0];
    assign w_up_d  = {1'b0, r_wr} - {1'b0, w_bsw};
    assign w_up    = w_up_d[RING_AW] ? RING_AW'(w_up_d + (RING_AW+1)'(RING))
                                     : w_up_d[RING_AW-1:0];

    assign i_pix.ready = (r_cred < FIFO_CW'(FIFO_DEPTH));
    assign w_acc  = i_pix.valid && i_pix.ready;
    assign w_pix  = w_acc && !i_pix.mode;
    assign w_drn  = w_acc && i_pix.mode;
    assign w_emit = w_acc && (i_pix.mode ? (r_pend != '0) : (r_pend >= w_lag));

    assign w_out_int = (r_out_row >= FH_W'(HALF))
        && ((FH_W+1)'(r_out_row) + (FH_W+1)'(HALF + 1) < (FH_W+1)'(w_h))
        && (r_out_col >= COL_AW'(HALF))
        && ((W_W+1)'(r_out_col) + (W_W+1)'(HALF + 1) < (W_W+1)'(w_w));
    assign w_out_last   = (r_out_row == w_h - 1'b1) && (W_W'(r_out_col) == w_w - 1'b1);
    assign w_in_col_end = (W_W'(r_in_col) == w_w - 1'b1);
    assign w_in_row_end = (r_in_row == w_h - 1'b1);

    amt_ram #(.WIDTH(PIX_W), .DEPTH(RING)) u_ls_ctr (
        .i_clk   (i_clk),
        .i_we    (w_pix),
        .i_waddr (r_wr),
        .i_wdata (i_pix.pixel),
        .i_re    (w_acc),
        .i_raddr (w_pos),
        .o_rdata (w_ctr_rdata)
    );

    amt_ram #(.WIDTH(PIX_W), .DEPTH(RING)) u_ls_up (
        .i_clk   (i_clk),
        .i_we    (w_pix),
        .i_waddr (r_wr),
        .i_wdata (i_pix.pixel),
        .i_re    (w_pix),
        .i_raddr (w_up),
        .o_rdata (w_up_rdata)
    );

    assign w_col_old = (r_fwd_vld && r_fwd_col == r_col1) ? r_fwd_val : w_col_rdata;
    assign w_colnew  = COL_W'((r_row0_1 ? (COL_W+1)'(0) : (COL_W+1)'(w_col_old))
                     + (COL_W+1)'(r_px1)
                     - (r_sub1 ? (COL_W+1)'(w_up_rdata) : (COL_W+1)'(0)));

    amt_ram #(.WIDTH(COL_W), .DEPTH(MAX_WIDTH)) u_col (
        .i_clk   (i_clk),
        .i_we    (r_v1 && r_pi1),
        .i_waddr (r_col1),
        .i_wdata (w_colnew),
        .i_re    (w_pix),
        .i_raddr (r_in_col),
        .o_rdata (w_col_rdata)
    );

    assign w_ws_n = WS_W'((r_c0_2 ? (WS_W+1)'(0) : (WS_W+1)'(r_ws))
                  + (WS_W+1)'(r_colnew2)
                  - (r_cge2 ? (WS_W+1)'(r_shift[BLOCK_SIZE-1]) : (WS_W+1)'(0)));

    assign w_mean    = r_prod4 >> SHIFT;
    assign w_lhs     = PROD_W'(r_cpix4) + PROD_W'(r_thr);
    assign w_res_pix = r_int4 ? ((w_lhs < w_mean) ? '0 : PIX_W'(PIX_MAX)) : r_cpix4;
    assign w_push    = r_v4 && r_em4;
    assign w_pop     = o_res.valid && o_res.ready;

    assign o_res.valid     = (r_fifo_cnt != '0);
    assign o_res.out_pixel = r_fifo[r_fifo_rp].pix;
    assign o_res.out_last  = r_fifo[r_fifo_rp].last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr      <= THR_RST;
            r_fw       <= FW_RST;
            r_fh       <= FH_RST;
            r_wr       <= '0;
            r_pend     <= '0;
            r_in_col   <= '0;
            r_in_row   <= '0;
            r_out_col  <= '0;
            r_out_row  <= '0;
            r_v1       <= 1'b0;
            r_v2       <= 1'b0;
            r_v3       <= 1'b0;
            r_v4       <= 1'b0;
            r_cred     <= '0;
            r_fifo_cnt <= '0;
            r_fifo_wp  <= '0;
            r_fifo_rp  <= '0;
            r_fwd_vld  <= 1'b0;
        end else begin
            r_v1 <= w_acc;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            if (r_v1 && r_pi1) begin
                r_fwd_vld <= 1'b1;
            end
            if (w_pix) begin
                r_wr <= (r_wr == RING_AW'(RING - 1)) ? '0 : r_wr + 1'b1;
                if (!w_emit) begin
                    r_pend <= r_pend + 1'b1;
                end
                if (w_in_col_end) begin
                    r_in_col <= '0;
                    r_in_row <= w_in_row_end ? '0 : r_in_row + 1'b1;
                end else begin
                    r_in_col <= r_in_col + 1'b1;
                end
            end
            if (w_drn && w_emit) begin
                r_pend <= r_pend - 1'b1;
            end
            if (w_emit) begin
                if (W_W'(r_out_col) == w_w - 1'b1) begin
                    r_out_col <= '0;
                    r_out_row <= (r_out_row == w_h - 1'b1) ? '0 : r_out_row + 1'b1;
                end else begin
                    r_out_col <= r_out_col + 1'b1;
                end
            end
            r_cred     <= r_cred + FIFO_CW'(w_emit) - FIFO_CW'(w_pop);
            r_fifo_cnt <= r_fifo_cnt + FIFO_CW'(w_push) - FIFO_CW'(w_pop);
            if (w_push) begin
                r_fifo_wp <= r_fifo_wp + 1'b1;
            end
            if (w_pop) begin
                r_fifo_rp <= r_fifo_rp + 1'b1;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_THRESHOLD: begin
                        r_thr <= i_cfg_wdata[THR_W-1:0];
                    end
                    CFG_FRAME_WIDTH: begin
                        r_fw      <= i_cfg_wdata[FW_W-1:0];
                        r_pend    <= '0;
                        r_in_col  <= '0;
                        r_in_row  <= '0;
                        r_out_col <= '0;
                        r_out_row <= '0;
                    end
                    CFG_FRAME_HEIGHT: begin
                        r_fh      <= i_cfg_wdata[FH_W-1:0];
                        r_pend    <= '0;
                        r_in_col  <= '0;
                        r_in_row  <= '0;
                        r_out_col <= '0;
                        r_out_row <= '0;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_em1    <= w_emit;
        r_pi1    <= w_pix;
        r_px1    <= i_pix.pixel;
        r_col1   <= r_in_col;
        r_row0_1 <= (r_in_row == '0);
        r_sub1   <= (r_in_row >= FH_W'(BLOCK_SIZE));
        r_c0_1   <= (r_in_col == '0);
        r_cge1   <= (r_in_col >= COL_AW'(BLOCK_SIZE));
        r_int1   <= w_out_int;
        r_last1  <= w_out_last;

        if (r_v1 && r_pi1) begin
            r_fwd_col <= r_col1;
            r_fwd_val <= w_colnew;
        end
        r_em2     <= r_em1;
        r_pi2     <= r_pi1;
        r_c0_2    <= r_c0_1;
        r_cge2    <= r_cge1;
        r_int2    <= r_int1;
        r_last2   <= r_last1;
        r_colnew2 <= w_colnew;
        r_cpix2   <= w_ctr_rdata;

        if (r_v2 && r_pi2) begin
            r_ws       <= w_ws_n;
            r_shift[0] <= r_colnew2;
            for (int i = 1; i < BLOCK_SIZE; i++) begin
                r_shift[i] <= r_shift[i-1];
            end
        end
        r_em3   <= r_em2;
        r_int3  <= r_int2;
        r_last3 <= r_last2;
        r_ws3   <= r_pi2 ? w_ws_n : r_ws;
        r_cpix3 <= r_cpix2;

        r_em4   <= r_em3;
        r_int4  <= r_int3;
        r_last4 <= r_last3;
        r_prod4 <= PROD_W'(r_ws3) * PROD_W'(RECIP);
        r_cpix4 <= r_cpix3;

        if (w_push) begin
            r_fifo[r_fifo_wp] <= '{pix: w_res_pix, last: r_last4};
        end
    end

    `AMT_ASSERT(a_cred_bound, r_cred <= FIFO_CW'(FIFO_DEPTH), "result credit overflow")
    `AMT_ASSERT(a_fifo_in_cred, r_fifo_cnt <= r_cred, "queued results exceed reservations")
    `AMT_ASSERT(a_pend_bound, r_pend <= w_lag, "pending count beyond window lag")
    `AMT_ASSERT_IMPL(a_push_room, w_push, (r_fifo_cnt != FIFO_CW'(FIFO_DEPTH)) || w_pop, "queue full on push")
    `AMT_ASSERT_IMPL(a_emit_reach, r_v1 && r_em1, ##3 w_push, "emitting word lost in pipeline")
endmodule

// ===== hdl/amt_ram.sv =====
// Generic single-write, single-read RAM with registered read data
module amt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== sim/adaptive_mean_threshold_test.sv =====
// Testbench for adaptive_mean_threshold: random frames checked against a scoreboard predictor
`timescale 1ns / 1ps
module adaptive_mean_threshold_test;
    import amt_pkg::*;

    localparam int HALF      = 7;
    localparam int WIN_AREA  = 225;
    localparam int MAX_W     = 1024;
    localparam int RING_LEN  = 17 * MAX_W;
    localparam int MAX_CYCLES = 2000000;

    class threshold_scoreboard;
        byte unsigned ring[RING_LEN];
        int thr, fw, fh;
        int wr_pos, pend, out_idx;
        int errors;
        t_res expected_q[$];

        function new();
            thr = THR_RST;
            fw = FW_RST;
            fh = FH_RST;
            wr_pos = 0;
            pend = 0;
            out_idx = 0;
            errors = 0;
            foreach (ring[i]) ring[i] = 0;
        endfunction

        function int eff_w();
            int w;
            w = (fw > MAX_W) ? MAX_W : fw;
            return (w == 0) ? 1 : w;
        endfunction

        function int eff_h();
            return (fh == 0) ? 1 : fh;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
            case (idx)
                CFG_THRESHOLD: thr = v & 12'hFF;
                CFG_FRAME_WIDTH: begin
                    fw = v & 12'h7FF;
                    out_idx = 0;
                    pend = 0;
                end
                CFG_FRAME_HEIGHT: begin
                    fh = v;
                    out_idx = 0;
                    pend = 0;
                end
                default: ;
            endcase
        endfunction

        function void push_result();
            int w, h, r, c, pos, pix, sum, mean, k;
            t_res e;
            w = eff_w();
            h = eff_h();
            r = out_idx / w;
            c = out_idx % w;
            pos = (wr_pos + RING_LEN - (pend % RING_LEN)) % RING_LEN;
            pix = ring[pos];
            e.pix = pix;
            if (r >= HALF && r < h - HALF - 1 && c >= HALF && c < w - HALF - 1) begin
                sum = 0;
                for (int dr = -HALF; dr <= HALF; dr++) begin
                    for (int dc = -HALF; dc <= HALF; dc++) begin
                        k = (pos + dr * w + dc) % RING_LEN;
                        if (k < 0) k += RING_LEN;
                        sum += ring[k];
                    end
                end
                mean = sum / WIN_AREA;
                e.pix = (pix < mean - thr) ? 8'd0 : 8'd255;
            end
            e.last = (out_idx == w * h - 1);
            expected_q.push_back(e);
            out_idx++;
            if (out_idx >= w * h) out_idx = 0;
            pend--;
        endfunction

        function void note_word(logic m, logic [PIX_W-1:0] p);
            if (m) begin
                if (pend != 0) push_result();
            end else begin
                ring[wr_pos] = p;
                wr_pos = (wr_pos + 1) % RING_LEN;
                pend++;
                if (pend > HALF * eff_w() + HALF) push_result();
            end
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task check(logic [PIX_W-1:0] pix, logic last);
            t_res e;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected word pix=%0d last=%0d", pix, last));
            end else begin
                e = expected_q.pop_front();
                if (pix !== e.pix)
                    report($sformatf("out_pixel %0d, want %0d", pix, e.pix));
                if (last !== e.last)
                    report($sformatf("out_last %0d, want %0d", last, e.last));
            end
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    amt_in_if pix_ch ();
    amt_out_if res_ch ();

    adaptive_mean_threshold u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_pix       (pix_ch),
        .o_res       (res_ch)
    );

    threshold_scoreboard sb = new();
    bit steady;
    bit hold_req;
    int cycles;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > MAX_CYCLES) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) sb.check(res_ch.out_pixel, res_ch.out_last);
    end

    initial begin
        int stall;
        stall = 0;
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                stall = 400;
                hold_req = 0;
            end else if (stall == 0 && !steady && $urandom_range(0, 4) == 0) begin
                stall = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60) : $urandom_range(1, 3);
            end
            if (stall > 0) begin
                res_ch.ready <= 1'b0;
                stall--;
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int v);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_reg(idx, v);
        @(negedge i_clk);
    endtask

    task automatic send_word(logic m, logic [PIX_W-1:0] p);
        int gap;
        if (!steady && $urandom_range(0, 3) == 0) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
            pix_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        pix_ch.valid <= 1'b1;
        pix_ch.mode <= m;
        pix_ch.pixel <= p;
        do @(posedge i_clk); while (!pix_ch.ready);
        sb.note_word(m, p);
        @(negedge i_clk);
    endtask

    task automatic settle();
        pix_ch.valid <= 1'b0;
        @(negedge i_clk);
        while (sb.expected_q.size() != 0) @(negedge i_clk);
        repeat (30) @(negedge i_clk);
    endtask

    function automatic logic [PIX_W-1:0] gen_pixel(bit smooth, int base);
        int v;
        if (!smooth || $urandom_range(0, 15) == 0) return $urandom_range(0, 255);
        v = base + $urandom_range(0, 30) - 15;
        if (v < 0) v = 0;
        if (v > PIX_MAX) v = PIX_MAX;
        return v;
    endfunction

    task automatic run_phase(int thr, int fw, int fh, int npix, bit smooth, bit drain,
                             bit pressure);
        int base, n;
        settle();
        write_reg(CFG_THRESHOLD, thr);
        write_reg(CFG_FRAME_WIDTH, fw);
        write_reg(CFG_FRAME_HEIGHT, fh);
        send_word(1'b1, $urandom_range(0, 255));
        base = $urandom_range(30, 225);
        for (int i = 0; i < npix; i++) begin
            if (i % 64 == 0) base = $urandom_range(30, 225);
            if (pressure && i == npix / 2) hold_req = 1;
            send_word(1'b0, gen_pixel(smooth, base));
        end
        if (drain) begin
            n = sb.pend;
            repeat (n + 1) send_word(1'b1, $urandom_range(0, 255));
        end
    endtask

    initial begin
        logic [PIX_W-1:0] edge_pix[16];
        int w, h;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_wdata = '0;
        pix_ch.valid = 1'b0;
        pix_ch.mode = 1'b0;
        pix_ch.pixel = '0;
        steady = 0;
        hold_req = 0;
        cycles = 0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        edge_pix = '{8'd0, 8'd255, 8'd1, 8'd254, 8'h55, 8'hAA, 8'd128, 8'd127,
                     8'd0, 8'd255, 8'h0F, 8'hF0, 8'd2, 8'd64, 8'd200, 8'd7};
        write_reg(CFG_THRESHOLD, 0);
        write_reg(CFG_FRAME_WIDTH, 0);
        write_reg(CFG_FRAME_HEIGHT, 0);
        send_word(1'b1, 8'd0);
        foreach (edge_pix[i]) send_word(1'b0, edge_pix[i]);
        repeat (16) send_word(1'b1, 8'd0);

        run_phase(0, 16, 16, 512, 1, 1, 0);
        run_phase($urandom_range(1, 20), 17, 19, 17 * 19, 1, 1, 1);
        steady = 1;
        run_phase(255, 16, 16, 256, 0, 1, 0);
        steady = 0;
        run_phase(10, 16, 4095, 200, 1, 0, 0);
        w = $urandom_range(16, 24);
        h = $urandom_range(16, 20);
        run_phase($urandom_range(0, 40), w, h, w * h, 1, 1, $urandom_range(0, 1));

        settle();
        if (sb.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
